FILE: rtl/lccb_pkg.sv
// ----------------------------------------------------------------------------
// lccb_pkg: shared constants for the bgr555 lcd color correction block
// field widths of the pixel input and the 16-bit channel outputs
// ----------------------------------------------------------------------------
`default_nettype none

package lccb_pkg;

  // pixel is three 5-bit channels, red in the low bits
  localparam int unsigned ChanW = 5;
  localparam int unsigned PixW  = 3 * ChanW;

  // every output channel is a 16-bit intensity
  localparam int unsigned OutW = 16;

endpackage : lccb_pkg

`default_nettype wire

FILE: rtl/lcd_color_correct_bgr555_top.sv
// ----------------------------------------------------------------------------
// lcd_color_correct_bgr555_top: bgr555 to 16-bit rgb with lcd color emulation
// a transferred pixel passes four register stages (capture, linearize, mix,
//   gamma lookup) before its result is on the result ports with valid_o high
// throughput: one pixel per clock; busy stays low, the pipeline never stalls
//   and the receiver cannot hold results off
// reset: clears the valid bits and color_emulation; the tables are constants,
//   so there is no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_color_correct_bgr555_top #(
  parameter int unsigned LINEAR_FRAC_BITS = 16,
  parameter int unsigned GAMMA_INDEX_BITS = 11
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration: color_emulation register
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  // pixel command
  input  logic                       start,
  output logic                       busy,
  input  logic [lccb_pkg::PixW-1:0]  bgr_color_i,
  // result strobe
  output logic                       valid_o,
  output logic [lccb_pkg::OutW-1:0]  red_out_o,
  output logic [lccb_pkg::OutW-1:0]  green_out_o,
  output logic [lccb_pkg::OutW-1:0]  blue_out_o
);

  localparam int unsigned ChanW    = lccb_pkg::ChanW;
  localparam int unsigned OutW     = lccb_pkg::OutW;
  localparam int unsigned PixW     = lccb_pkg::PixW;
  // linear value reaches 2^F for a full channel
  localparam int unsigned LinW     = LINEAR_FRAC_BITS + 1;
  // largest weight row sum is 305, below 2^9
  localparam int unsigned SumW     = LINEAR_FRAC_BITS + 9;
  localparam int unsigned IdxShift = LINEAR_FRAC_BITS - 2;
  localparam int unsigned IdxFullW = SumW - IdxShift;

  // channel mixing weights, rows are red, green, blue outputs
  localparam logic [SumW-1:0] WeightRR = SumW'(255);
  localparam logic [SumW-1:0] WeightRG = SumW'(50);
  localparam logic [SumW-1:0] WeightGR = SumW'(10);
  localparam logic [SumW-1:0] WeightGG = SumW'(230);
  localparam logic [SumW-1:0] WeightGB = SumW'(30);
  localparam logic [SumW-1:0] WeightBR = SumW'(50);
  localparam logic [SumW-1:0] WeightBG = SumW'(10);
  localparam logic [SumW-1:0] WeightBB = SumW'(220);

  // (c/31)^4 rounded half up, F fraction bits
  localparam logic [63:0] LinHalf = 64'd923521;
  localparam logic [63:0] LinDen  = 64'd1847042;

  function automatic logic [LinW-1:0] lin_value(input logic [ChanW-1:0] c);
    logic [63:0] c4;
    logic [63:0] num;
    c4  = 64'(c) * 64'(c) * 64'(c) * 64'(c);
    num = ((c4 << LINEAR_FRAC_BITS) << 1) + LinHalf;
    return LinW'(num / LinDen);
  endfunction

  function automatic logic [31:0][LinW-1:0] build_lin();
    logic [31:0][LinW-1:0] t;
    int unsigned c;
    for (c = 0; c < 32; c++) t[c] = lin_value(ChanW'(c));
    return t;
  endfunction

  localparam logic [31:0][LinW-1:0] LinTab = build_lin();

  // plain widening by bit replication
  function automatic logic [OutW-1:0] widen5(input logic [ChanW-1:0] v);
    return {v, v, v, v[ChanW-1]};
  endfunction

  // configuration register
  logic color_emulation_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_emulation_q <= 1'b0;
    end else if (cfg_we_i) begin
      color_emulation_q <= cfg_wdata_i;
    end
  end

  // no back pressure anywhere, a pixel can enter every cycle
  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // stage 1: captured pixel, mode taken at the transfer
  logic            s1_valid_q;
  logic            s1_mode_q;
  logic [PixW-1:0] s1_pix_q;

  // stage 2: linearized channels
  logic            s2_valid_q;
  logic            s2_mode_q;
  logic [PixW-1:0] s2_pix_q;
  logic [LinW-1:0] s2_lin_q [3];

  // stage 3: mixed sums
  logic            s3_valid_q;
  logic            s3_mode_q;
  logic [PixW-1:0] s3_pix_q;
  logic [SumW-1:0] s3_sum_d [3];
  logic [SumW-1:0] s3_sum_q [3];

  // stage 4: gamma lookup (inside the roms) and widened bypass
  logic            s4_valid_q;
  logic            s4_mode_q;
  logic [OutW-1:0] s4_wide_q [3];
  logic [OutW-1:0] rom_data [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_mode_q  <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_mode_q  <= 1'b0;
      s3_valid_q <= 1'b0;
      s3_mode_q  <= 1'b0;
      s4_valid_q <= 1'b0;
      s4_mode_q  <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s1_mode_q  <= color_emulation_q;
      s2_valid_q <= s1_valid_q;
      s2_mode_q  <= s1_mode_q;
      s3_valid_q <= s2_valid_q;
      s3_mode_q  <= s2_mode_q;
      s4_valid_q <= s3_valid_q;
      s4_mode_q  <= s3_mode_q;
    end
  end

  // mixing: constant weights, one row per output channel (no blue into red)
  always_comb begin
    s3_sum_d[0] = WeightRR * SumW'(s2_lin_q[0]) + WeightRG * SumW'(s2_lin_q[1]);
    s3_sum_d[1] = WeightGR * SumW'(s2_lin_q[0]) + WeightGG * SumW'(s2_lin_q[1])
                + WeightGB * SumW'(s2_lin_q[2]);
    s3_sum_d[2] = WeightBR * SumW'(s2_lin_q[0]) + WeightBG * SumW'(s2_lin_q[1])
                + WeightBB * SumW'(s2_lin_q[2]);
  end

  // payload registers move every cycle, valid bits mark the real transfers
  always_ff @(posedge clk_i) begin
    s1_pix_q    <= bgr_color_i;
    s2_pix_q    <= s1_pix_q;
    s2_lin_q[0] <= LinTab[s1_pix_q[ChanW-1:0]];
    s2_lin_q[1] <= LinTab[s1_pix_q[2*ChanW-1:ChanW]];
    s2_lin_q[2] <= LinTab[s1_pix_q[3*ChanW-1:2*ChanW]];
    s3_pix_q    <= s2_pix_q;
    for (int ch = 0; ch < 3; ch++) begin
      s3_sum_q[ch] <= s3_sum_d[ch];
    end
    s4_wide_q[0] <= widen5(s3_pix_q[ChanW-1:0]);
    s4_wide_q[1] <= widen5(s3_pix_q[2*ChanW-1:ChanW]);
    s4_wide_q[2] <= widen5(s3_pix_q[3*ChanW-1:2*ChanW]);
  end

  // gamma index per channel, saturated to the last table entry
  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    logic [IdxFullW-1:0]         idx_full;
    logic [GAMMA_INDEX_BITS-1:0] rom_addr;

    assign idx_full = s3_sum_q[ch][SumW-1:IdxShift];

    if (GAMMA_INDEX_BITS >= IdxFullW) begin : g_fit
      // every index lands inside the table
      assign rom_addr = GAMMA_INDEX_BITS'(idx_full);
    end else begin : g_sat
      assign rom_addr = (|idx_full[IdxFullW-1:GAMMA_INDEX_BITS]) ? '1
                      : idx_full[GAMMA_INDEX_BITS-1:0];
    end

    lccb_gamma_rom #(
      .INDEX_BITS (GAMMA_INDEX_BITS)
    ) u_gamma_rom (
      .clk_i  (clk_i),
      .addr_i (rom_addr),
      .data_o (rom_data[ch])
    );
  end

  // result transfer
  assign valid_o     = s4_valid_q;
  assign red_out_o   = s4_mode_q ? rom_data[0] : s4_wide_q[0];
  assign green_out_o = s4_mode_q ? rom_data[1] : s4_wide_q[1];
  assign blue_out_o  = s4_mode_q ? rom_data[2] : s4_wide_q[2];

endmodule : lcd_color_correct_bgr555_top

`default_nettype wire

FILE: rtl/lccb_gamma_rom.sv
// ----------------------------------------------------------------------------
// lccb_gamma_rom: display gamma lookup with registered read
// entry i holds round(59683 * (i/1020)^(5/11)) capped at 65535, built exactly at elaboration
// ----------------------------------------------------------------------------
`default_nettype none

module lccb_gamma_rom #(
  parameter int unsigned INDEX_BITS = 11
) (
  input  logic                       clk_i,
  input  logic [INDEX_BITS-1:0]      addr_i,
  output logic [lccb_pkg::OutW-1:0]  data_o
);

  localparam int unsigned Depth = 1 << INDEX_BITS;
  // wide enough for i^5 * 119366^11 at the largest index
  localparam int unsigned BigW = 272;
  localparam logic [BigW-1:0] OutScale2 = BigW'(119366);
  localparam logic [BigW-1:0] InScale5  =
      BigW'(64'd1020 * 64'd1020 * 64'd1020 * 64'd1020 * 64'd1020);

  // largest y with (2y-1)^11 * 1020^5 <= i^5 * 119366^11, capped at 65535
  function automatic logic [lccb_pkg::OutW-1:0] gamma_entry(input logic [INDEX_BITS-1:0] i);
    logic [BigW-1:0] rhs;
    logic [BigW-1:0] lhs;
    logic [BigW-1:0] x;
    logic [BigW-1:0] x2;
    logic [BigW-1:0] x4;
    logic [BigW-1:0] x8;
    logic [16:0]     lo;
    logic [16:0]     hi;
    logic [16:0]     mid;
    int              k;
    rhs = BigW'(1);
    for (k = 0; k < 5; k++) rhs = rhs * BigW'(i);
    for (k = 0; k < 11; k++) rhs = rhs * OutScale2;
    lo = 17'd0;
    hi = 17'd65535;
    for (k = 0; k < 16; k++) begin
      if (lo < hi) begin
        mid = (lo + hi + 17'd1) >> 1;
        x   = (BigW'(mid) << 1) - BigW'(1);
        x2  = x * x;
        x4  = x2 * x2;
        x8  = x4 * x4;
        lhs = x8 * x2 * x * InScale5;
        if (lhs <= rhs) begin
          lo = mid;
        end else begin
          hi = mid - 17'd1;
        end
      end
    end
    return lo[lccb_pkg::OutW-1:0];
  endfunction

  function automatic logic [Depth-1:0][lccb_pkg::OutW-1:0] build_rom();
    logic [Depth-1:0][lccb_pkg::OutW-1:0] t;
    int unsigned n;
    for (n = 0; n < Depth; n++) t[n] = gamma_entry(INDEX_BITS'(n));
    return t;
  endfunction

  localparam logic [Depth-1:0][lccb_pkg::OutW-1:0] GammaRom = build_rom();

  logic [lccb_pkg::OutW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= GammaRom[addr_i];
  end

  assign data_o = data_q;

endmodule : lccb_gamma_rom

`default_nettype wire

FILE: rtl/lccb_checker.sv
// ----------------------------------------------------------------------------
// lccb_checker: port level checks for the lcd color correction block
// watches transfers, result timing, black pixels and the plain widening path
// ----------------------------------------------------------------------------
`default_nettype none

module lccb_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       cfg_we_i,
  input logic                       cfg_wdata_i,
  input logic                       start,
  input logic                       busy,
  input logic [lccb_pkg::PixW-1:0]  bgr_color_i,
  input logic                       valid_o,
  input logic [lccb_pkg::OutW-1:0]  red_out_o,
  input logic [lccb_pkg::OutW-1:0]  green_out_o,
  input logic [lccb_pkg::OutW-1:0]  blue_out_o
);

  logic [lccb_pkg::OutW-1:0] red_wide;
  logic [lccb_pkg::OutW-1:0] blue_wide;

  assign red_wide  = {bgr_color_i[4:0], bgr_color_i[4:0], bgr_color_i[4:0], bgr_color_i[4]};
  assign blue_wide = {bgr_color_i[14:10], bgr_color_i[14:10], bgr_color_i[14:10],
                      bgr_color_i[14]};

  // the block never holds a command off
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // one result strobe per command, none after a reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o == ($past(start && !busy, 4) && $past(rst_ni, 4) && $past(rst_ni, 3)
                && $past(rst_ni, 2) && $past(rst_ni, 1)))
    else $error("result strobe does not match command transfer");

  // black maps to zero in either mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && ($past(bgr_color_i, 4) == 15'd0)
    |-> (red_out_o == 16'd0) && (green_out_o == 16'd0) && (blue_out_o == 16'd0))
    else $error("black pixel gave nonzero output");

  // emulation just switched off: red and blue outputs are replicated channel bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(cfg_we_i, 5) && !$past(cfg_wdata_i, 5) && !$past(cfg_we_i, 4)
    |-> (red_out_o == $past(red_wide, 4)) && (blue_out_o == $past(blue_wide, 4)))
    else $error("plain widening mismatch");

endmodule : lccb_checker

bind lcd_color_correct_bgr555_top lccb_checker u_lccb_checker (.*);

`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for lcd_color_correct_bgr555_top
// drives bgr555 pixels through the command port, rewrites the color_emulation
// register between phases and compares every red/green/blue result against a typed-in value or an
// in-bench model of the bit widening and the lcd gamma/matrix path
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ChanW        = lccb_pkg::ChanW;
  localparam int unsigned PixW         = lccb_pkg::PixW;
  localparam int unsigned OutW         = lccb_pkg::OutW;
  localparam int unsigned LinFrac      = 16;
  localparam int unsigned GammaIdxBits = 11;
  localparam int unsigned GammaSize    = 1 << GammaIdxBits;
  localparam int unsigned GammaShift   = LinFrac - 2;
  localparam int unsigned ClkPeriod    = 12;
  localparam int unsigned ResetCycles  = 10;
  // gamma table entries: (2y-1)^11 * InScale^5 <= i^5 * OutScale2^11
  localparam longint unsigned OutScale2 = 119366;
  localparam longint unsigned InScale   = 1020;
  localparam longint unsigned Lin31Pow4 = 923521;
  // mixing weights, rows are red, green, blue outputs
  localparam longint unsigned WRR = 255, WRG = 50,  WRB = 0;
  localparam longint unsigned WGR = 10,  WGG = 230, WGB = 30;
  localparam longint unsigned WBR = 50,  WBG = 10,  WBB = 220;
  // run shape
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned PhaseItems    = 190;
  localparam int unsigned DrainLimit    = 2000;
  localparam int unsigned TailCycles    = 8;
  localparam int unsigned TimeoutCycles = 100_000;

  typedef struct packed {
    logic [OutW-1:0] red;
    logic [OutW-1:0] green;
    logic [OutW-1:0] blue;
  } rgb_t;

  // one directed row: register setting, pixel, and a typed-in result if known
  typedef struct packed {
    logic            emul;
    logic [PixW-1:0] pix;
    logic            typed;
    rgb_t            rgb;
  } pixel_row_t;

  localparam int unsigned DirRows = 22;
  localparam pixel_row_t DirTab [DirRows] = '{
    // plain widening straight out of reset
    '{1'b0, 15'h0000, 1'b1, '{16'h0000, 16'h0000, 16'h0000}},
    '{1'b0, 15'h7fff, 1'b1, '{16'hffff, 16'hffff, 16'hffff}},
    '{1'b0, 15'h001f, 1'b1, '{16'hffff, 16'h0000, 16'h0000}},
    '{1'b0, 15'h03e0, 1'b1, '{16'h0000, 16'hffff, 16'h0000}},
    '{1'b0, 15'h7c00, 1'b1, '{16'h0000, 16'h0000, 16'hffff}},
    '{1'b0, 15'h0001, 1'b1, '{16'h0842, 16'h0000, 16'h0000}},
    '{1'b0, 15'h4210, 1'b1, '{16'h8421, 16'h8421, 16'h8421}},
    '{1'b0, 15'h5555, 1'b0, '0},
    // lcd emulation: black, white, pure channels, low and high grays, mixed patterns
    '{1'b1, 15'h0000, 1'b1, '{16'h0000, 16'h0000, 16'h0000}},
    '{1'b1, 15'h7fff, 1'b0, '0},
    '{1'b1, 15'h001f, 1'b0, '0},
    '{1'b1, 15'h03e0, 1'b0, '0},
    '{1'b1, 15'h7c00, 1'b0, '0},
    '{1'b1, 15'h0001, 1'b0, '0},
    '{1'b1, 15'h0421, 1'b0, '0},
    '{1'b1, 15'h4210, 1'b0, '0},
    '{1'b1, 15'h2aaa, 1'b0, '0},
    '{1'b1, 15'h5555, 1'b0, '0},
    '{1'b1, 15'h7bde, 1'b0, '0},
    '{1'b1, 15'h0842, 1'b0, '0},
    // and back to widening
    '{1'b0, 15'h7fff, 1'b1, '{16'hffff, 16'hffff, 16'hffff}},
    '{1'b0, 15'h2aaa, 1'b0, '0}
  };

  // register setting per random phase, both extremes and a same-value rewrite
  localparam bit PhaseEmul [NumPhases] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

  // dut ports, the driven ones known from time zero
  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic            cfg_wdata_i = 1'b0;
  logic            start       = 1'b0;
  logic            busy;
  logic [PixW-1:0] bgr_color_i = '0;
  logic            valid_o;
  logic [OutW-1:0] red_out_o;
  logic [OutW-1:0] green_out_o;
  logic [OutW-1:0] blue_out_o;

  // typed-in expectation travels along with the pixel it belongs to
  logic            drv_typed = 1'b0;
  rgb_t            drv_rgb   = '0;

  // model state
  logic [16:0]     lin_tab   [32];
  logic [OutW-1:0] gamma_tab [GammaSize];
  logic            emul_model = 1'b0;
  rgb_t            rgb_due_q [$];

  // bookkeeping
  int unsigned err_count       = 0;
  int unsigned results_checked = 0;
  int unsigned pixels_sent     = 0;
  int unsigned emul_pixels     = 0;
  int unsigned cfg_writes      = 0;
  bit          idle_on         = 1'b1;

  lcd_color_correct_bgr555_top #(
    .LINEAR_FRAC_BITS (LinFrac),
    .GAMMA_INDEX_BITS (GammaIdxBits)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start       (start),
    .busy        (busy),
    .bgr_color_i (bgr_color_i),
    .valid_o     (valid_o),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o)
  );

  initial begin
    forever #(ClkPeriod / 2.0) clk_i = ~clk_i;
  end

  // hard stop in case the pipeline hangs
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // model of the color path
  // ---------------------------------------------------------------------------

  // largest y with (2y-1)^11 * InScale^5 <= i^5 * OutScale2^11, exact in 288 bits
  function automatic logic [OutW-1:0] gamma_root(int unsigned idx);
    bit [287:0]  rhs;
    bit [287:0]  lhs;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    rhs = 288'd1;
    for (int k = 0; k < 5; k++) rhs = rhs * idx;
    for (int k = 0; k < 11; k++) rhs = rhs * OutScale2;
    lo = 0;
    hi = 65535;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = 288'd1;
      for (int k = 0; k < 11; k++) lhs = lhs * (2 * mid - 1);
      for (int k = 0; k < 5; k++) lhs = lhs * InScale;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[OutW-1:0];
  endfunction

  task automatic build_color_tables();
    longint unsigned c4;
    for (int c = 0; c < 32; c++) begin
      c4 = longint'(c) * c * c * c;
      // (c/31)^4 rounded half up, L(31) is exactly 2^F
      lin_tab[c] = 17'(((c4 << LinFrac) * 2 + Lin31Pow4) / (2 * Lin31Pow4));
    end
    for (int i = 0; i < GammaSize; i++) gamma_tab[i] = gamma_root(i);
  endtask

  function automatic logic [OutW-1:0] widen5(logic [ChanW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return OutW'((w << 11) | (w << 6) | (w << 1) | (w >> 4));
  endfunction

  // mixed sum to output channel, index saturates at the last table entry
  function automatic logic [OutW-1:0] gamma_lookup(longint unsigned sum);
    longint unsigned idx;
    idx = sum >> GammaShift;
    if (idx > GammaSize - 1) idx = GammaSize - 1;
    return gamma_tab[idx];
  endfunction

  function automatic rgb_t correct_pixel(logic [PixW-1:0] pix, logic emul);
    logic [ChanW-1:0] r5;
    logic [ChanW-1:0] g5;
    logic [ChanW-1:0] b5;
    longint unsigned  lr;
    longint unsigned  lg;
    longint unsigned  lb;
    rgb_t             res;
    r5 = pix[ChanW-1:0];
    g5 = pix[2*ChanW-1:ChanW];
    b5 = pix[3*ChanW-1:2*ChanW];
    if (!emul) begin
      res.red   = widen5(r5);
      res.green = widen5(g5);
      res.blue  = widen5(b5);
    end else begin
      lr = lin_tab[r5];
      lg = lin_tab[g5];
      lb = lin_tab[b5];
      res.red   = gamma_lookup(WRR * lr + WRG * lg + WRB * lb);
      res.green = gamma_lookup(WGR * lr + WGG * lg + WGB * lb);
      res.blue  = gamma_lookup(WBR * lr + WBG * lg + WBB * lb);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: checks results, tracks the register, queues each accepted pixel
  // ---------------------------------------------------------------------------

  task automatic check_channel(string name, logic [OutW-1:0] want, logic [OutW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni) begin
      // result strobe lasts one cycle, nothing can hold it off
      if (valid_o) begin
        if (rgb_due_q.size() == 0) begin
          $error("result with no pixel outstanding: red %h green %h blue %h",
                 red_out_o, green_out_o, blue_out_o);
          err_count++;
        end else begin
          want = rgb_due_q.pop_front();
          check_channel("red_out", want.red, red_out_o);
          check_channel("green_out", want.green, green_out_o);
          check_channel("blue_out", want.blue, blue_out_o);
          results_checked++;
        end
      end
      if (cfg_we_i) emul_model = cfg_wdata_i;
      // pixel transfer: typed-in rows bypass the model
      if (start && !busy) begin
        rgb_due_q.push_back(drv_typed ? drv_rgb : correct_pixel(bgr_color_i, emul_model));
        if (emul_model) emul_pixels++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // called right after a rising edge; returns at the edge of the transfer or after
  // a random idle burst, start stays high if the next pixel follows back to back
  task automatic send_pixel(logic [PixW-1:0] pix, logic typed, rgb_t rgb);
    start       <= 1'b1;
    bgr_color_i <= pix;
    drv_typed   <= typed;
    drv_rgb     <= rgb;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pixels_sent++;
    // random idle burst on the sender side
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // stop sending and let every queued result come out
  task automatic wait_pipeline_empty();
    start <= 1'b0;
    do @(negedge clk_i); while (rgb_due_q.size() != 0);
    @(posedge clk_i);
  endtask

  task automatic write_emulation(logic v);
    wait_pipeline_empty();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_writes++;
  endtask

  // half uniform, half built mostly from channel corners 0, 1, 30 and 31
  function automatic logic [PixW-1:0] random_pixel();
    logic [ChanW-1:0] ch [3];
    if ($urandom_range(0, 1) == 0) return PixW'($urandom_range(0, 32767));
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 2) == 0) ch[k] = ChanW'($urandom_range(0, 31));
      else if ($urandom_range(0, 1) == 0) ch[k] = ChanW'($urandom_range(0, 1));
      else ch[k] = ChanW'(31 - $urandom_range(0, 1));
    end
    return {ch[2], ch[1], ch[0]};
  endfunction

  initial begin
    logic        cur_emul;
    int unsigned drain_cycles;
    int unsigned leftover;

    build_color_tables();

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows, register follows the table
    cur_emul = 1'b0;
    foreach (DirTab[i]) begin
      if (DirTab[i].emul != cur_emul) begin
        write_emulation(DirTab[i].emul);
        cur_emul = DirTab[i].emul;
      end
      send_pixel(DirTab[i].pix, DirTab[i].typed, DirTab[i].rgb);
    end

    // random phases, one register setting each
    for (int p = 0; p < NumPhases; p++) begin
      write_emulation(PhaseEmul[p]);
      for (int n = 0; n < PhaseItems; n++) begin
        // stretches with and without idling, none in the last phase
        if (p == NumPhases - 1) idle_on = 1'b0;
        else if (n % 25 == 0) idle_on = ($urandom_range(0, 2) != 0);
        send_pixel(random_pixel(), 1'b0, '0);
      end
    end

    // drain, then wait out TailCycles for any stray strobe
    start <= 1'b0;
    drain_cycles = 0;
    do begin
      @(negedge clk_i);
      drain_cycles++;
    end while (rgb_due_q.size() != 0 && drain_cycles < DrainLimit);
    repeat (TailCycles) @(posedge clk_i);

    leftover = rgb_due_q.size();
    if (leftover != 0) begin
      $error("%0d results never arrived", leftover);
      err_count += leftover;
    end

    $display("run covered %0d pixels, %0d with color emulation, over %0d register writes",
             pixels_sent, emul_pixels, cfg_writes);
    $display("%0d results compared channel by channel, %0d mismatches",
             results_checked, err_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule : testbench

`default_nettype wire

FILE: filelist.f
rtl/lccb_pkg.sv
rtl/lccb_gamma_rom.sv
rtl/lcd_color_correct_bgr555_top.sv
rtl/lccb_checker.sv
tb/sv/testbench.sv
